// File: rtl/rgef_pkg.sv
// rgef_pkg: shared types and constants for the RGB gradient edge filter.
// No dependencies.
package rgef_pkg;

	localparam int unsigned NUM_CH     = 3;
	localparam int unsigned ROOT_STEPS = 8;
	localparam logic [7:0]  CH_MAX     = 8'd255;

	// lane 0 is red, in the lowest bits
	typedef logic [NUM_CH-1:0][7:0] pix_t;

	typedef struct packed {
		logic frame_end;
		logic last;
		pix_t pix;
	} res_t;

	typedef struct packed {
		logic has_first;
		logic interior;
		logic first_last;
		logic has_second;
		logic frame_end;
	} item_ctl_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

// File: rtl/rgb_gradient_edge_filter.sv
// rgb_gradient_edge_filter: streaming inverted central-difference gradient magnitude.
// Two line memories, an 8-step square root per channel, 2-entry result buffer; uses rgef_pkg.
// Each pixel is accepted, then the memories are read and the squares formed; interior pixels
// then run 8 root steps, and any pixel with results loads the buffer. No new pixel is accepted
// until this is done; the load waits until the result buffer is empty.
// Reset (arst_n low): counters, FSM and result buffer clear, width 640, height 480; no mem clear.
module rgb_gradient_edge_filter #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out, green_out, blue_out
	output logic        m_tlast,   // last_of_item
	output logic [0:0]  m_tuser    // frame_end
);
	import rgef_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = (AW + 1 > 12) ? AW + 1 : 12;
	localparam int unsigned SW = $clog2(ROOT_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_ROOT,
		S_PUSH
	} state_t;

	logic [11:0]    width_q;
	logic [15:0]    height_q;
	logic [CW-1:0]  w_ext;
	logic [AW:0]    eff_w;
	logic [15:0]    eff_h;
	logic [AW-1:0]  col_q;
	logic [15:0]    row_q;
	logic           col_last;
	logic           row_last;
	logic           cfg_wr;
	logic           accept;
	logic           pop;

	state_t         state_q;
	logic [SW-1:0]  step_q;
	res_t           ob_q [2];
	logic [1:0]     ob_cnt_q;

	pix_t           cur_q;
	logic [AW-1:0]  addr_q;
	item_ctl_t      ctl_q;
	item_ctl_t      ctl_d;

	pix_t           prev_mem [MAX_WIDTH];
	pix_t           older_mem [MAX_WIDTH];
	pix_t           prev_c_q;
	pix_t           prev_r_q;
	pix_t           older_c_q;
	pix_t           left_q;

	logic [15:0]    rad_q   [NUM_CH];
	logic [7:0]     root_q  [NUM_CH];
	logic [9:0]     rem_q   [NUM_CH];
	logic [7:0]     dif_h   [NUM_CH];
	logic [7:0]     dif_v   [NUM_CH];
	logic [15:0]    sq_sum  [NUM_CH];
	logic [11:0]    rem_t   [NUM_CH];
	logic [11:0]    trial   [NUM_CH];
	logic [11:0]    rem_sub [NUM_CH];
	logic           ge      [NUM_CH];
	pix_t           res_pix;
	res_t           first_res;
	res_t           second_res;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_WIDTH:  prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	assign w_ext = CW'(width_q);
	assign eff_w = (width_q == 12'd0) ? (AW+1)'(1) :
		(w_ext > CW'(MAX_WIDTH)) ? (AW+1)'(MAX_WIDTH) : (AW+1)'(w_ext);
	assign eff_h = (height_q == 16'd0) ? 16'd1 : height_q;

	assign col_last = ((AW+1)'(col_q) + (AW+1)'(1)) == eff_w;
	assign row_last = (17'(row_q) + 17'd1) == 17'(eff_h);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	assign m_tdata  = ob_q[0].pix;
	assign m_tlast  = ob_q[0].last;
	assign m_tuser  = ob_q[0].frame_end;

	always_comb begin
		ctl_d.has_first  = (row_q != 16'd0);
		ctl_d.interior   = (col_q != '0) && !col_last && (row_q != 16'd1);
		ctl_d.first_last = !row_last;
		ctl_d.has_second = row_last;
		ctl_d.frame_end  = col_last;
	end

	// registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 16'd480;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_WIDTH:  width_q  <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[15:0];
				default:    ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// line memories: read on accept, write back in the read cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_c_q  <= prev_mem[col_q];
			prev_r_q  <= prev_mem[col_q + AW'(1)];
			older_c_q <= older_mem[col_q];
		end
		if (state_q == S_READ) begin
			prev_mem[addr_q]  <= cur_q;
			older_mem[addr_q] <= prev_c_q;
		end
	end

	// per-channel differences, squares and root step
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			dif_h[i] = (prev_r_q[i] >= left_q[i]) ? prev_r_q[i] - left_q[i]
				: left_q[i] - prev_r_q[i];
			dif_v[i] = (cur_q[i] >= older_c_q[i]) ? cur_q[i] - older_c_q[i]
				: older_c_q[i] - cur_q[i];
			sq_sum[i] = 16'(dif_h[i][7:1]) * 16'(dif_h[i][7:1])
				+ 16'(dif_v[i][7:1]) * 16'(dif_v[i][7:1]);
			rem_t[i]   = {rem_q[i], rad_q[i][15:14]};
			trial[i]   = {2'b00, root_q[i], 2'b01};
			ge[i]      = rem_t[i] >= trial[i];
			rem_sub[i] = rem_t[i] - trial[i];
			res_pix[i] = CH_MAX - (root_q[i] + 8'(rem_q[i] != 10'd0));
		end
	end

	always_comb begin
		first_res.frame_end  = 1'b0;
		first_res.last       = ctl_q.first_last;
		first_res.pix        = ctl_q.interior ? res_pix : '0;
		second_res.frame_end = ctl_q.frame_end;
		second_res.last      = 1'b1;
		second_res.pix       = '0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= s_tdata;
			addr_q <= col_q;
			ctl_q  <= ctl_d;
		end
		if (state_q == S_READ) begin
			left_q <= prev_c_q;
			for (int i = 0; i < NUM_CH; i++) begin
				rad_q[i]  <= sq_sum[i];
				root_q[i] <= '0;
				rem_q[i]  <= '0;
			end
		end
		if (state_q == S_ROOT) begin
			for (int i = 0; i < NUM_CH; i++) begin
				rad_q[i]  <= {rad_q[i][13:0], 2'b00};
				root_q[i] <= {root_q[i][6:0], ge[i]};
				rem_q[i]  <= ge[i] ? rem_sub[i][9:0] : rem_t[i][9:0];
			end
		end
	end

	// sequencer and result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			ob_cnt_q <= 2'd0;
			ob_q[0]  <= '0;
			ob_q[1]  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_READ;
				end
				S_READ: begin
					step_q <= '0;
					if (!ctl_q.has_first && !ctl_q.has_second) begin
						state_q <= S_IDLE;
					end else if (ctl_q.has_first && ctl_q.interior) begin
						state_q <= S_ROOT;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_ROOT: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(ROOT_STEPS - 1)) state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (ob_cnt_q == 2'd0) begin
						if (ctl_q.has_first) begin
							ob_q[0]  <= first_res;
							ob_q[1]  <= second_res;
							ob_cnt_q <= ctl_q.has_second ? 2'd2 : 2'd1;
						end else begin
							ob_q[0]  <= second_res;
							ob_cnt_q <= 2'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (pop) begin
				ob_q[0]  <= ob_q[1];
				ob_cnt_q <= ob_cnt_q - 2'd1;
			end
		end
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_READ)
		else $error("accepted transaction did not enter memory read");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("frame end without last_of_item");

	a_push_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && ob_cnt_q == 2'd0) |=> (ob_cnt_q != 2'd0 && state_q == S_IDLE))
		else $error("result buffer load lost");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW+1)'(col_q) < eff_w)
		else $error("column counter beyond row width");

	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= 2'd2)
		else $error("result buffer overflow");

endmodule

// File: bench/rgb_gradient_edge_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rgb_gradient_edge_filter: a directed script, then random frame
// settings with random pixels, checked against typed results and a behavioral gradient predictor.
// Depends on rgef_pkg and the rgb_gradient_edge_filter RTL.
module rgb_gradient_edge_filter_tb;
	import rgef_pkg::*;

	localparam int unsigned LINE_MAX     = 2048;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned SETTLE       = 24;
	localparam int unsigned DRAIN_LIMIT  = 20000;
	localparam int unsigned TIMEOUT_NS   = 10_000_000;

	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		reg_idx_t    idx;
		logic [31:0] val;
		pix_t        pix;
		bit          typed;
		int          n;
		res_t        r0;
		res_t        r1;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [23:0] s_tdata;   // red_in, green_in, blue_in
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;   // red_out, green_out, blue_out
	logic        m_tlast;   // last_of_item
	logic [0:0]  m_tuser;   // frame_end

	// predictor state
	pix_t        row_above [LINE_MAX];
	pix_t        row_two_up [LINE_MAX];
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	int unsigned col_pos, row_pos;
	res_t        expected_edges [$];

	bit          src_steady, sink_steady;
	int          sink_hold;
	int unsigned errors, pixels_sent, results_seen, frames_seen, settings_run;

	rgb_gradient_edge_filter #(.MAX_WIDTH(LINE_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= 40) $display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned half_sq(logic [7:0] a, logic [7:0] b);
		int unsigned m;
		m = (a >= b) ? a - b : b - a;
		m = m >> 1;
		return m * m;
	endfunction

	// 255 minus the rounded-up root
	function automatic logic [7:0] inv_root(int unsigned s);
		int unsigned r;
		r = 0;
		while (r * r < s) r++;
		return CH_MAX - 8'(r);
	endfunction

	function automatic int unsigned eff_width(logic [11:0] w);
		if (w == 0) return 1;
		if (w > LINE_MAX) return LINE_MAX;
		return w;
	endfunction

	function automatic int unsigned eff_height(logic [15:0] h);
		return (h == 0) ? 1 : h;
	endfunction

	function automatic res_t res_of(pix_t p, bit last, bit fend);
		res_t r;
		r.pix = p;
		r.last = last;
		r.frame_end = fend;
		return r;
	endfunction

	task automatic predict_gradient(input pix_t p, input bit store);
		int unsigned w, h, x, y;
		res_t r;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		x = (col_pos >= w) ? 0 : col_pos;
		y = (row_pos >= h) ? 0 : row_pos;
		if (y >= 1) begin
			r = res_of('0, y + 1 != h, 1'b0);
			if (x != 0 && x + 1 != w && y != 1) begin
				for (int c = 0; c < NUM_CH; c++)
					r.pix[c] = inv_root(half_sq(row_above[x + 1][c], row_two_up[x - 1][c])
						+ half_sq(p[c], row_two_up[x][c]));
			end
			if (store) expected_edges.push_back(r);
		end
		row_two_up[x] = row_above[x];
		row_above[x] = p;
		if (y + 1 == h && store) expected_edges.push_back(res_of('0, 1'b1, x + 1 == w));
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h) y = 0;
		end
		col_pos = x;
		row_pos = y;
	endtask

	// entered and left at a falling edge
	task automatic send_pixel(input pix_t p, input bit typed, input int tn,
			input res_t t0, input res_t t1);
		int gap;
		gap = src_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = p;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_gradient(p, !typed);
		if (typed && tn > 0) expected_edges.push_back(t0);
		if (typed && tn > 1) expected_edges.push_back(t1);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_WIDTH) width_reg = val[11:0];
		else height_reg = val[15:0];
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_read(input reg_idx_t idx, input logic [31:0] want);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			flag_mismatch($sformatf("register %s read %h, want %h", idx.name(), prdata, want));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// block idle: every result in, then room for pixels that produce none
	task automatic settle_out();
		s_tvalid = 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic step_t cfg_step(reg_idx_t idx, logic [31:0] val);
		step_t s;
		s.kind = STEP_CFG;
		s.idx = idx;
		s.val = val;
		s.pix = '0;
		s.typed = 1'b0;
		s.n = 0;
		s.r0 = '0;
		s.r1 = '0;
		return s;
	endfunction

	function automatic step_t pix_step(pix_t p, bit typed, int n, res_t r0, res_t r1);
		step_t s;
		s.kind = STEP_PIX;
		s.idx = REG_WIDTH;
		s.val = '0;
		s.pix = p;
		s.typed = typed;
		s.n = n;
		s.r0 = r0;
		s.r1 = r1;
		return s;
	endfunction

	function automatic pix_t rand_pixel();
		pix_t p;
		for (int c = 0; c < NUM_CH; c++) begin
			case ($urandom_range(0, 5))
				0: p[c] = 8'h00;
				1: p[c] = 8'hFF;
				default: p[c] = 8'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	initial begin
		m_tready = 1'b1;
		sink_hold = 0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready = 1'b0;
				sink_hold--;
			end else begin
				m_tready = 1'b1;
				if (!sink_steady) sink_hold = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0]) frames_seen++;
			if (expected_edges.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h last %b fend %b",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = expected_edges.pop_front();
				if (m_tdata !== want.pix)
					flag_mismatch($sformatf("pixel %h, want %h", m_tdata, want.pix));
				if (m_tlast !== want.last)
					flag_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
				if (m_tuser[0] !== want.frame_end)
					flag_mismatch($sformatf("frame end %b, want %b", m_tuser, want.frame_end));
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		step_t       script [$];
		res_t        none, zl, zn;
		logic [11:0] wv;
		logic [15:0] hv;
		int unsigned ew, eh, n, random_px, k;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		frames_seen = 0;
		settings_run = 0;
		width_reg = 12'd640;
		height_reg = 16'd480;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < LINE_MAX; i++) begin
			row_above[i] = '0;
			row_two_up[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_read(REG_WIDTH, 32'd640);
		apb_read(REG_HEIGHT, 32'd480);

		none = '0;
		zl = res_of('0, 1'b1, 1'b0);
		zn = res_of('0, 1'b0, 1'b0);
		// 3x3 frame, one interior pixel with full-scale differences on both axes
		script.push_back(cfg_step(REG_WIDTH, 32'd3));
		script.push_back(cfg_step(REG_HEIGHT, 32'd3));
		script.push_back(pix_step(24'h000000, 1, 0, none, none));
		script.push_back(pix_step(24'h000000, 1, 0, none, none));
		script.push_back(pix_step(24'hFFFFFF, 1, 0, none, none));
		script.push_back(pix_step(24'h000000, 1, 1, zl, none));
		script.push_back(pix_step(24'hAAAAAA, 1, 1, zl, none));
		script.push_back(pix_step(24'hFFFFFF, 1, 1, zl, none));
		script.push_back(pix_step(24'hFFFFFF, 1, 2, zn, zl));
		script.push_back(pix_step(24'hFFFFFF, 1, 2, res_of(24'h4B4B4B, 1'b0, 1'b0), zl));
		script.push_back(pix_step(24'h000000, 1, 2, zn, res_of('0, 1'b1, 1'b1)));
		// second frame, mixed channels
		script.push_back(pix_step(24'h0180FE, 0, 0, none, none));
		script.push_back(pix_step(24'h7F7F7F, 0, 0, none, none));
		script.push_back(pix_step(24'hFE0180, 0, 0, none, none));
		script.push_back(pix_step(24'h55AA33, 0, 0, none, none));
		script.push_back(pix_step(24'h00FFFF, 0, 0, none, none));
		script.push_back(pix_step(24'hC3C3C3, 0, 0, none, none));
		script.push_back(pix_step(24'hFF0000, 0, 0, none, none));
		script.push_back(pix_step(24'h0F0F0F, 0, 0, none, none));
		script.push_back(pix_step(24'h80FF01, 0, 0, none, none));
		// single-row frame
		script.push_back(cfg_step(REG_WIDTH, 32'd2));
		script.push_back(cfg_step(REG_HEIGHT, 32'd1));
		script.push_back(pix_step(24'h123456, 1, 1, zl, none));
		script.push_back(pix_step(24'hABCDEF, 1, 1, res_of('0, 1'b1, 1'b1), none));
		// zero sizes behave as one
		script.push_back(cfg_step(REG_WIDTH, 32'd0));
		script.push_back(cfg_step(REG_HEIGHT, 32'd0));
		script.push_back(pix_step(24'hFFFFFF, 1, 1, res_of('0, 1'b1, 1'b1), none));
		script.push_back(pix_step(24'h000000, 1, 1, res_of('0, 1'b1, 1'b1), none));

		foreach (script[i]) begin
			if (script[i].kind == STEP_CFG) begin
				settle_out();
				apb_write(script[i].idx, script[i].val);
			end else begin
				send_pixel(script[i].pix, script[i].typed, script[i].n,
					script[i].r0, script[i].r1);
			end
		end

		random_px = 0;
		while (random_px < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 3))
						0: wv = 12'd0;
						1: wv = 12'd1;
						2: wv = 12'd2048;
						default: wv = 12'd4095;
					endcase
					hv = 16'($urandom_range(1, 4));
				end
				1: begin
					wv = 12'($urandom_range(1, 10));
					case ($urandom_range(0, 2))
						0: hv = 16'd0;
						1: hv = 16'd1;
						default: hv = 16'd65535;
					endcase
				end
				default: begin
					wv = 12'($urandom_range(1, 10));
					hv = 16'($urandom_range(1, 6));
				end
			endcase
			ew = eff_width(wv);
			eh = eff_height(hv);
			settle_out();
			src_steady = ($urandom_range(0, 4) == 0);
			sink_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1)) begin
				apb_write(REG_WIDTH, 32'(wv));
				apb_write(REG_HEIGHT, 32'(hv));
			end else begin
				apb_write(REG_HEIGHT, 32'(hv));
				apb_write(REG_WIDTH, 32'(wv));
			end
			apb_read(REG_WIDTH, 32'(wv));
			apb_read(REG_HEIGHT, 32'(hv));
			// small frames: whole frames plus a partial one, so some settings end mid-frame
			if (ew * eh > 60) n = $urandom_range(60, 150);
			else n = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
			repeat (n) send_pixel(rand_pixel(), 1'b0, 0, none, none);
			random_px += n;
			settings_run++;
		end

		s_tvalid = 1'b0;
		src_steady = 1'b0;
		k = 0;
		while (expected_edges.size() != 0 && k < DRAIN_LIMIT) begin
			@(posedge clk);
			k++;
		end
		repeat (SETTLE) @(posedge clk);
		while (expected_edges.size() != 0) begin
			flag_mismatch($sformatf("result never came: %h", expected_edges[0].pix));
			void'(expected_edges.pop_front());
		end

		$display("Sent %0d pixels over %0d random frame settings plus the directed script;",
			pixels_sent, settings_run);
		$display("received %0d results, %0d of them frame ends.", results_seen, frames_seen);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
